### design/incremental_position_hash_128_core_assert.svh
// Assertion macros for the checker file of the position hash core.
`ifndef INCREMENTAL_POSITION_HASH_128_CORE_ASSERT_SVH
`define INCREMENTAL_POSITION_HASH_128_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/iph_pkg.sv
// Shared types, constants and helper functions of the position hash core.
package iph_pkg;

	// Hash constants: golden ratio, seeds of the two halves, finalizer multipliers.
	localparam logic [63:0] GOLD_K  = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SEED_LO = 64'h243f6a8885a308d3;
	localparam logic [63:0] SEED_HI = 64'h13198a2e03707344;
	localparam logic [63:0] FIN_M1  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] FIN_M2  = 64'h94d049bb133111eb;

	// Beat widths: input payload is 66 field bits padded to 9 bytes.
	localparam int IN_W   = 72;
	localparam int USER_W = 3;
	localparam int OUT_W  = 128;

	// Toggle kinds; the code doubles as the domain number.
	typedef enum logic [2:0] {
		ACT_CLEAR  = 3'd0,
		ACT_BSIZE  = 3'd1,
		ACT_STONE  = 3'd2,
		ACT_CAPT   = 3'd3,
		ACT_PLY    = 3'd4,
		ACT_OPEN   = 3'd5,
		ACT_LAST   = 3'd6,
		ACT_PLAYER = 3'd7
	} action_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MIX1,
		ST_MUL2,
		ST_FIN,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic pp_en;
		logic mul_sel;
		logic mix_en;
		logic fin_en;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic skip;
	} status_t;

	// Domain number times the golden constant, modulo 2^64, as shifted adds.
	function automatic logic [63:0] gold_times(input logic [2:0] dom);
		logic [63:0] sum;
		sum = dom[0] ? GOLD_K : 64'd0;
		if (dom[1])
			sum = sum + {GOLD_K[62:0], 1'b0};
		if (dom[2])
			sum = sum + {GOLD_K[61:0], 2'b00};
		return sum;
	endfunction

endpackage

### design/incremental_position_hash_128_core.sv
// Top level of the incremental 128-bit position hash core.
// Each input beat applies one toggle to a 128-bit hash and returns the new hash as
// one result beat. A toggle runs both 64-bit splitmix64 finalizer lanes in
// parallel, each on one multiplier that both rounds share. From the input beat it
// steps through accept, two multiply rounds (partial products, then recombine),
// and the load of the result register, which waits while that register is full.
// A clear or a zero-stone toggle goes from accept straight to the load. The next
// input beat is accepted in the cycle after the load, while the previous result
// may still wait in the output register, so the core takes one toggle at a time.
module incremental_position_hash_128_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// point[15:0], stone_code[23:16], player_slot[24], capture_count[32:25],
	// ply_count[48:33], opening_flag[49], player_code[57:50], edge_len[65:58]
	input  logic [iph_pkg::IN_W-1:0]    s_tdata,
	// action[2:0]
	input  logic [iph_pkg::USER_W-1:0]  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// hash_low[63:0], hash_high[127:64]
	output logic [iph_pkg::OUT_W-1:0]   m_tdata
);
	import iph_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	iph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// Hash datapath.
	iph_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.in_action (s_tuser),
		.cmd       (cmd),
		.status    (status),
		.hash      (m_tdata)
	);

endmodule

### design/iph_mul64.sv
// Low 64 bits of 64x64 product; low and cross-sum 32x32 products registered.
module iph_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);
	logic [63:0] ll_q;
	logic [31:0] cross_q;
	logic [31:0] ah_bl;
	logic [31:0] al_bh;

	// Cross terms only contribute their low halves to the truncated product.
	assign ah_bl = a[63:32] * b[31:0];
	assign al_bh = a[31:0] * b[63:32];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_q    <= a[31:0] * b[31:0];
			cross_q <= ah_bl + al_bh;
		end
	end

	// Recombine in the following cycle.
	assign p = ll_q + {cross_q, 32'd0};

endmodule

### design/iph_dpath.sv
// Datapath: toggle value build, two finalizer lanes, hash halves and output register.
module iph_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [iph_pkg::IN_W-1:0]  in_data,
	input  logic [iph_pkg::USER_W-1:0] in_action,
	input  iph_pkg::cmd_t             cmd,
	output iph_pkg::status_t          status,
	output logic [iph_pkg::OUT_W-1:0] hash
);
	import iph_pkg::*;

	action_t     act;
	logic [15:0] point;
	logic [7:0]  stone_code;
	logic        player_slot;
	logic [7:0]  capture_count;
	logic [15:0] ply_count;
	logic        opening_flag;
	logic [7:0]  player_code;
	logic [7:0]  edge_len;
	logic [63:0] value;
	logic [63:0] base;
	logic [63:0] x_lo;
	logic [63:0] x_hi;
	logic [63:0] mul_b;
	logic [63:0] prod_lo;
	logic [63:0] prod_hi;
	logic [63:0] mix_lo_q;
	logic [63:0] mix_hi_q;
	logic [63:0] acc_lo_q;
	logic [63:0] acc_hi_q;
	logic [OUT_W-1:0] hash_q;

	// Field unpacking, lowest bits first.
	assign act           = action_t'(in_action);
	assign point         = in_data[15:0];
	assign stone_code    = in_data[23:16];
	assign player_slot   = in_data[24];
	assign capture_count = in_data[32:25];
	assign ply_count     = in_data[48:33];
	assign opening_flag  = in_data[49];
	assign player_code   = in_data[57:50];
	assign edge_len      = in_data[65:58];

	// Value of the toggle for each kind.
	always_comb begin
		case (act)
			ACT_BSIZE:  value = {56'd0, edge_len};
			ACT_STONE:  value = {40'd0, point, stone_code};
			ACT_CAPT:   value = {55'd0, player_slot, capture_count};
			ACT_PLY:    value = {48'd0, ply_count};
			ACT_OPEN:   value = {63'd0, opening_flag};
			ACT_LAST:   value = {48'd0, point};
			ACT_PLAYER: value = {{56{player_code[7]}}, player_code};
			default:    value = 64'd0;
		endcase
	end

	// Clear and empty stone toggles need no token.
	assign status.skip = (act == ACT_CLEAR) || ((act == ACT_STONE) && (stone_code == 8'd0));

	// Finalizer input of each lane.
	assign base = gold_times(in_action) ^ (value + GOLD_K);
	assign x_lo = SEED_LO ^ base;
	assign x_hi = SEED_HI ^ base;

	// Both lanes share the multiplier constant of the current round.
	assign mul_b = cmd.mul_sel ? FIN_M2 : FIN_M1;

	iph_mul64 u_mul_lo (
		.clk (clk),
		.en  (cmd.pp_en),
		.a   (mix_lo_q),
		.b   (mul_b),
		.p   (prod_lo)
	);

	iph_mul64 u_mul_hi (
		.clk (clk),
		.en  (cmd.pp_en),
		.a   (mix_hi_q),
		.b   (mul_b),
		.p   (prod_hi)
	);

	// Mixing registers: first xor-shift at accept, second after round one.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mix_lo_q <= x_lo ^ (x_lo >> 30);
			mix_hi_q <= x_hi ^ (x_hi >> 30);
		end else if (cmd.mix_en) begin
			mix_lo_q <= prod_lo ^ (prod_lo >> 27);
			mix_hi_q <= prod_hi ^ (prod_hi >> 27);
		end
	end

	// Hash halves: cleared by a clear beat, toggled by the finished tokens.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_lo_q <= 64'd0;
			acc_hi_q <= 64'd0;
		end else if (cmd.start && (act == ACT_CLEAR)) begin
			acc_lo_q <= 64'd0;
			acc_hi_q <= 64'd0;
		end else if (cmd.fin_en) begin
			acc_lo_q <= acc_lo_q ^ prod_lo ^ (prod_lo >> 31);
			acc_hi_q <= acc_hi_q ^ prod_hi ^ (prod_hi >> 31);
		end
	end

	// Output register holds the result beat until it is taken.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			hash_q <= {acc_hi_q, acc_lo_q};
		end
	end

	assign hash = hash_q;

endmodule

### design/iph_ctrl.sv
// Controller: sequences accept, two multiply rounds, hash update and result beat.
module iph_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  iph_pkg::status_t  status,
	output iph_pkg::cmd_t     cmd
);
	import iph_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new beat when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.skip ? ST_EMIT : ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MIX1;
			ST_MIX1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_FIN;
			ST_FIN:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_MUL1: cmd.pp_en = 1'b1;
			ST_MIX1: cmd.mix_en = 1'b1;
			ST_MUL2: begin
				cmd.pp_en   = 1'b1;
				cmd.mul_sel = 1'b1;
			end
			ST_FIN:  cmd.fin_en = 1'b1;
			ST_EMIT: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/iph_checker.sv
// Port-level checker of the position hash core and its bind.
`include "incremental_position_hash_128_core_assert.svh"

module iph_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [iph_pkg::IN_W-1:0]    s_tdata,
	input logic [iph_pkg::USER_W-1:0]  s_tuser,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [iph_pkg::OUT_W-1:0]   m_tdata
);
	import iph_pkg::*;

	logic in_beat;
	logic token_beat;

	assign in_beat    = s_tvalid && s_tready;
	assign token_beat = in_beat && (s_tuser != ACT_CLEAR)
		&& !((s_tuser == ACT_STONE) && (s_tdata[23:16] == 8'd0));

	// A stalled result beat keeps its value.
	`IPH_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

	// One item at a time: no input beat right after an accepted one.
	`IPH_ASSERT_NEXT(a_one_item, clk, arst_n, in_beat, !s_tready, "input accepted while busy")

	// A token toggle keeps the input closed for its two multiply rounds.
	`IPH_ASSERT_NEXT(a_token_busy, clk, arst_n, token_beat, !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready, "token toggle finished too early")

	// A new result appears only after the input has been closed.
	`IPH_ASSERT_NOW(a_result_origin, clk, arst_n, $rose(m_tvalid), !$past(s_tready), "result beat without work in progress")

endmodule

bind incremental_position_hash_128_core iph_checker u_iph_checker (.*);
